>>> rtl/multichannel_moving_median_assert.svh
// assertion macros for the multichannel moving median block
// expects clk and rst in the scope of every use
`ifndef MULTICHANNEL_MOVING_MEDIAN_ASSERT_SVH
`define MULTICHANNEL_MOVING_MEDIAN_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define MMM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mmm same-cycle check failed");

// next-cycle implication, checked out of reset
`define MMM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mmm next-cycle check failed");

`else

`define MMM_ASSERT_SAME(label, ante, cons)
`define MMM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/mmm_pkg.sv
// shared constants and types of the multichannel moving median block
// no dependencies
package mmm_pkg;

  // default sizes
  localparam int DEF_CHANNELS = 32;
  localparam int DEF_WINDOW   = 64;

  // field widths of the stream beats
  localparam int SAMPLE_W  = 32;
  localparam int CHAN_W    = 5;
  localparam int WIDTH_W   = 6;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 32;

  // control of the shared rank counter
  typedef struct packed {
    logic clear;
    logic en;
  } rank_ctrl_t;

endpackage

>>> rtl/mmm_sample_ram.sv
// sample store: one write port, one read port with registered data
// depends on mmm_pkg
module mmm_sample_ram #(
  parameter int AW    = 11,
  parameter int DEPTH = 2048
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [mmm_pkg::SAMPLE_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [mmm_pkg::SAMPLE_W-1:0] rdata
);

  logic [mmm_pkg::SAMPLE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data registered and ready in the cycle after the address
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/mmm_rank_unit.sv
// shared rank counter: compares one stored sample a cycle against a candidate while enabled
// depends on mmm_pkg
module mmm_rank_unit #(
  parameter int NW = 7
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mmm_pkg::rank_ctrl_t                ctrl,
  input  logic signed [mmm_pkg::SAMPLE_W-1:0] cand,
  input  logic signed [mmm_pkg::SAMPLE_W-1:0] elem,
  output logic [NW-1:0]                      lt_cnt,
  output logic [NW-1:0]                      le_cnt
);

  logic is_lt;
  logic is_le;

  // signed order of the element against the candidate
  assign is_lt = elem < cand;
  assign is_le = elem <= cand;

  // counts of smaller and not-larger elements
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      lt_cnt <= '0;
      le_cnt <= '0;
    end else if (ctrl.en) begin
      lt_cnt <= lt_cnt + NW'(is_lt);
      le_cnt <= le_cnt + NW'(is_le);
    end
  end

endmodule

>>> rtl/multichannel_moving_median.sv
// Multichannel moving median. Each input beat names a channel and a window
// width and brings one sample; the sample goes into the channel's ring at the
// next write position and the beat returns the element at sorted position
// width/2 of the first width slots (upper median for even widths). A width of
// zero, above WINDOW, or a channel at or above CHANNELS returns 0 with the
// rejected flag and stores nothing. After reset the block clears the sample
// store and the write positions, one entry a cycle, for all
// CHANNELS * 2**clog2(WINDOW) entries (2048 at the defaults) before it takes
// the first beat. The median is found by rank counting in one shared
// comparator fed from the single read port of the sample store: each
// candidate slot is read and the first width slots are counted against it,
// and candidates are tried in slot order until one holds the wanted rank.
// One item is worked on at a time; the next beat is taken while the previous
// result still waits in the output register.
// depends on mmm_pkg, mmm_sample_ram, mmm_rank_unit, multichannel_moving_median_assert.svh
module multichannel_moving_median #(
  parameter int CHANNELS = mmm_pkg::DEF_CHANNELS,
  parameter int WINDOW   = mmm_pkg::DEF_WINDOW
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [5:0] window_width, [37:6] sample, [39:38] zero
  input  logic [mmm_pkg::S_TDATA_W-1:0] s_tdata,
  // [4:0] channel
  input  logic [mmm_pkg::CHAN_W-1:0]    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [31:0] median
  output logic [mmm_pkg::M_TDATA_W-1:0] m_tdata,
  // [0] rejected
  output logic                          m_tuser
);

  localparam int PW    = $clog2(WINDOW);
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW    = CW + PW;
  localparam int DEPTH = CHANNELS * (2 ** PW);
  localparam int NW    = PW + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POS,
    ST_CAND_RD,
    ST_CAND_LAT,
    ST_SCAN,
    ST_RESULT
  } state_t;

  state_t                        state;
  logic [AW-1:0]                 sweep;
  logic [CW-1:0]                 ch_q;
  logic [NW-1:0]                 width_q;
  logic [mmm_pkg::SAMPLE_W-1:0]  sample_q;
  logic [PW-1:0]                 cand_idx;
  logic [NW-1:0]                 scan_idx;
  logic                          cmp_en;
  logic [mmm_pkg::SAMPLE_W-1:0]  cand;
  logic [mmm_pkg::SAMPLE_W-1:0]  median_q;
  logic                          rejected_q;

  logic [PW-1:0]                 pos_mem [CHANNELS];
  logic [PW-1:0]                 pos_q;
  logic                          pos_we;
  logic [CW-1:0]                 pos_waddr;
  logic [PW-1:0]                 pos_wdata;
  logic [NW-1:0]                 pos_inc;
  logic [PW-1:0]                 pos_new;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [mmm_pkg::SAMPLE_W-1:0]  ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [mmm_pkg::SAMPLE_W-1:0]  ram_rdata;

  mmm_pkg::rank_ctrl_t           rank_ctrl;
  logic [NW-1:0]                 lt_cnt;
  logic [NW-1:0]                 le_cnt;
  logic [NW-1:0]                 target_rank;
  logic                          found;

  logic [mmm_pkg::WIDTH_W-1:0]   in_width;
  logic [mmm_pkg::SAMPLE_W-1:0]  in_sample;
  logic [mmm_pkg::CHAN_W-1:0]    in_channel;
  logic                          in_bad;

  // input beat fields
  assign in_width   = s_tdata[5:0];
  assign in_sample  = s_tdata[37:6];
  assign in_channel = s_tuser;
  assign in_bad     = (in_width == '0) || ({26'd0, in_width} > WINDOW) ||
                      ({27'd0, in_channel} >= CHANNELS);

  assign s_tready = (state == ST_IDLE);

  // write position memory, read with the channel of the incoming beat
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    pos_q <= pos_mem[CW'(in_channel)];
  end

  // advance the ring position, wrap when it reaches the width
  assign pos_inc = {1'b0, pos_q} + NW'(1);
  assign pos_new = (pos_inc >= width_q) ? '0 : pos_inc[PW-1:0];

  // memory port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {ch_q, pos_new};
    ram_wdata = sample_q;
    pos_we    = 1'b0;
    pos_waddr = ch_q;
    pos_wdata = pos_new;
    ram_raddr = {ch_q, scan_idx[PW-1:0]};
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep;
        ram_wdata = '0;
        pos_we    = 1'b1;
        pos_waddr = sweep[AW-1:PW];
        pos_wdata = '0;
      end
      ST_POS: begin
        ram_we = 1'b1;
        pos_we = 1'b1;
      end
      ST_CAND_RD: begin
        ram_raddr = {ch_q, cand_idx};
      end
      default: begin
      end
    endcase
  end

  mmm_sample_ram #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // rank counting against the current candidate
  assign rank_ctrl = '{clear: (state == ST_CAND_LAT), en: cmp_en};

  mmm_rank_unit #(
    .NW (NW)
  ) u_rank (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (rank_ctrl),
    .cand   (cand),
    .elem   (ram_rdata),
    .lt_cnt (lt_cnt),
    .le_cnt (le_cnt)
  );

  // candidate holds sorted position width/2 when lt <= k < le
  assign target_rank = width_q >> 1;
  assign found       = (lt_cnt <= target_rank) && (target_rank < le_cnt);

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      sweep    <= '0;
      cmp_en   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // drop a taken beat unless the result state loads the next one
      if (m_tvalid && m_tready && state != ST_RESULT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          sweep <= sweep + AW'(1);
          if (sweep == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            ch_q     <= CW'(in_channel);
            width_q  <= NW'(in_width);
            sample_q <= in_sample;
            cand_idx <= '0;
            if (in_bad) begin
              median_q   <= '0;
              rejected_q <= 1'b1;
              state      <= ST_RESULT;
            end else begin
              state <= ST_POS;
            end
          end
        end
        ST_POS: begin
          state <= ST_CAND_RD;
        end
        ST_CAND_RD: begin
          state <= ST_CAND_LAT;
        end
        ST_CAND_LAT: begin
          cand     <= ram_rdata;
          scan_idx <= '0;
          state    <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_idx != width_q) begin
            scan_idx <= scan_idx + NW'(1);
            cmp_en   <= 1'b1;
          end else begin
            cmp_en <= 1'b0;
          end
          if (scan_idx == width_q && !cmp_en) begin
            if (found) begin
              median_q   <= cand;
              rejected_q <= 1'b0;
              state      <= ST_RESULT;
            end else begin
              cand_idx <= cand_idx + PW'(1);
              state    <= ST_CAND_RD;
            end
          end
        end
        ST_RESULT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= median_q;
            m_tuser  <= rejected_q;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`include "multichannel_moving_median_assert.svh"

  // a rejected result carries a zero median
  `MMM_ASSERT_SAME(a_reject_zero, m_tvalid && m_tuser, m_tdata == '0)
  // one item at a time
  `MMM_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)
  // a new result only comes out of the result state
  `MMM_ASSERT_SAME(a_result_src, $rose(m_tvalid), $past(state == ST_RESULT))
  // the candidate search never runs past the window
  `MMM_ASSERT_SAME(a_cand_range, state == ST_SCAN, NW'(cand_idx) < width_q)

endmodule

>>> tb/mmm_median_checker.sv
// checker for the multichannel moving median: watches both stream channels,
// predicts each result from its own copy of the rings and compares field by field
// depends on mmm_pkg
module mmm_median_checker #(
  parameter int CHANNELS = mmm_pkg::DEF_CHANNELS,
  parameter int WINDOW   = mmm_pkg::DEF_WINDOW
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  // [5:0] window_width, [37:6] sample, [39:38] zero
  input  logic [mmm_pkg::S_TDATA_W-1:0] s_tdata,
  // [4:0] channel
  input  logic [mmm_pkg::CHAN_W-1:0]    s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  // [31:0] median
  input  logic [mmm_pkg::M_TDATA_W-1:0] m_tdata,
  // [0] rejected
  input  logic                          m_tuser,
  output int                            failures,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                                rejected;
    logic signed [mmm_pkg::SAMPLE_W-1:0] median;
  } median_result_t;

  // own copy of the per-channel rings and write positions
  logic signed [mmm_pkg::SAMPLE_W-1:0] ring_slot [CHANNELS][WINDOW];
  logic [mmm_pkg::WIDTH_W-1:0]         ring_pos  [CHANNELS];

  median_result_t median_q [$];
  median_result_t oldest;

  initial begin
    failures    = 0;
    outstanding = 0;
  end

  // store the sample at the advanced position, then rank the first width slots
  function automatic median_result_t predict_median(
    input logic [mmm_pkg::CHAN_W-1:0]          chan,
    input logic [mmm_pkg::WIDTH_W-1:0]         width,
    input logic signed [mmm_pkg::SAMPLE_W-1:0] sample
  );
    logic signed [mmm_pkg::SAMPLE_W-1:0] ranked [WINDOW];
    logic signed [mmm_pkg::SAMPLE_W-1:0] key;
    median_result_t                      res;
    int                                  next_pos;
    int                                  j;
    res = '0;
    if (width == 0 || int'(width) > WINDOW || int'(chan) >= CHANNELS) begin
      res.rejected = 1'b1;
      return res;
    end
    next_pos = int'(ring_pos[chan]) + 1;
    if (next_pos >= int'(width)) begin
      next_pos = 0;
    end
    ring_pos[chan] = mmm_pkg::WIDTH_W'(next_pos);
    ring_slot[chan][next_pos] = sample;
    // insertion sort, signed ascending
    for (int i = 0; i < int'(width); i++) begin
      key = ring_slot[chan][i];
      j = i;
      while (j > 0 && ranked[j-1] > key) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = key;
    end
    res.median = ranked[int'(width) / 2];
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        ring_pos[c] = '0;
        for (int k = 0; k < WINDOW; k++) begin
          ring_slot[c][k] = '0;
        end
      end
      median_q.delete();
    end else begin
      // result beat against the oldest prediction
      if (m_tvalid && m_tready) begin
        if (median_q.size() == 0) begin
          $error("result beat with nothing waiting: median %0d rejected %0b",
                 $signed(m_tdata), m_tuser);
          failures++;
        end else begin
          oldest = median_q.pop_front();
          if (m_tdata !== oldest.median) begin
            $error("median: expected %0d, got %0d", oldest.median, $signed(m_tdata));
            failures++;
          end
          if (m_tuser !== oldest.rejected) begin
            $error("rejected: expected %0b, got %0b", oldest.rejected, m_tuser);
            failures++;
          end
        end
      end
      // accepted input beat
      if (s_tvalid && s_tready) begin
        median_q.push_back(predict_median(s_tuser, s_tdata[mmm_pkg::WIDTH_W-1:0],
                                          s_tdata[mmm_pkg::WIDTH_W +: mmm_pkg::SAMPLE_W]));
      end
    end
    outstanding = median_q.size();
  end

endmodule

>>> tb/tb_top.sv
// top of the multichannel moving median testbench: clock, reset, bursty sample
// stimulus, a stalling result receiver, a watchdog and the verdict
// depends on mmm_pkg, multichannel_moving_median and mmm_median_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 650;
  localparam int MAX_GAP      = 20;
  localparam int MAX_STALL    = 12;
  localparam int CLEAR_CYCLES = mmm_pkg::DEF_CHANNELS * (1 << $clog2(mmm_pkg::DEF_WINDOW));

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [mmm_pkg::S_TDATA_W-1:0] s_tdata;
  logic [mmm_pkg::CHAN_W-1:0]    s_tuser;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [mmm_pkg::M_TDATA_W-1:0] m_tdata;
  logic                          m_tuser;

  int failures;
  int outstanding;

  // worst-case cycles of everything accepted so far, feeds the watchdog
  longint unsigned work_budget = CLEAR_CYCLES;
  longint unsigned cycle_count = 0;
  int unsigned     burst_left  = 0;
  int unsigned     stall_left  = 0;
  int unsigned     phase_left  = 0;
  bit              stall_phase = 1'b0;

  multichannel_moving_median dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  mmm_median_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 4 * work_budget + 20_000) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // receiver: calm stretches and stretches of random stalls, picked at random
  always @(negedge clk) begin
    if (phase_left == 0) begin
      stall_phase = 1'($urandom_range(0, 1));
      phase_left  = $urandom_range(20, 300);
    end else begin
      phase_left--;
    end
    if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (stall_phase && $urandom_range(0, 2) == 0) begin
      stall_left = $urandom_range(0, MAX_STALL - 1);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // one input beat, then a gap when the current burst runs out
  task automatic push_sample(input logic [mmm_pkg::CHAN_W-1:0] chan,
                             input logic [mmm_pkg::WIDTH_W-1:0] width,
                             input logic [mmm_pkg::SAMPLE_W-1:0] sample);
    longint unsigned w;
    w = 64'(width);
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, sample, width};
    s_tuser  <= chan;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    work_budget += w * (w + 4) + 3 + MAX_GAP + MAX_STALL + 8;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      s_tdata  <= mmm_pkg::S_TDATA_W'({$urandom, $urandom});
      s_tuser  <= mmm_pkg::CHAN_W'($urandom);
      repeat ($urandom_range(1, MAX_GAP)) @(negedge clk);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  // full-range values, small values that repeat, and the corners
  function automatic logic [mmm_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 4)) inside
      [0:2]:   return $urandom;
      3:       return mmm_pkg::SAMPLE_W'($urandom_range(0, 16)) - mmm_pkg::SAMPLE_W'(8);
      default: begin
        case ($urandom_range(0, 4))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h0000_0000;
          3:       return 32'hffff_ffff;
          default: return 32'h0000_0001;
        endcase
      end
    endcase
  endfunction

  initial begin
    logic [mmm_pkg::WIDTH_W-1:0] chan_width [mmm_pkg::DEF_CHANNELS];
    logic [mmm_pkg::CHAN_W-1:0]  hot_chan [4];
    logic [mmm_pkg::CHAN_W-1:0]  chan;
    logic [mmm_pkg::WIDTH_W-1:0] width;
    int unsigned                 r;

    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // zero width is refused, at both channel extremes
    push_sample(5'd0, 6'd0, 32'h7fff_ffff);
    push_sample(5'd31, 6'd0, 32'h8000_0000);
    // width one returns the sample itself
    push_sample(5'd0, 6'd1, 32'h8000_0000);
    push_sample(5'd0, 6'd1, 32'h7fff_ffff);
    // upper median of an even window, first with one slot still clear
    push_sample(5'd1, 6'd2, -32'sd5);
    push_sample(5'd1, 6'd2, 32'd7);
    push_sample(5'd1, 6'd2, -32'sd9);
    // odd window through both extremes
    push_sample(5'd2, 6'd3, 32'h8000_0000);
    push_sample(5'd2, 6'd3, 32'h7fff_ffff);
    push_sample(5'd2, 6'd3, 32'h0000_0000);
    push_sample(5'd2, 6'd3, 32'hffff_ffff);
    // widest window, mostly untouched slots
    push_sample(5'd3, 6'd63, 32'h7fff_ffff);
    push_sample(5'd3, 6'd63, 32'h8000_0000);
    push_sample(5'd3, 6'd63, 32'h0000_0001);
    // position left beyond a narrower width wraps to slot 0
    push_sample(5'd3, 6'd2, -32'sd3);
    push_sample(5'd3, 6'd4, 32'd5);
    // widths around the top width bit
    push_sample(5'd31, 6'd32, 32'h5555_5555);
    push_sample(5'd31, 6'd33, 32'haaaa_aaaa);
    // repeated values
    push_sample(5'd4, 6'd5, 32'hffff_ffff);
    push_sample(5'd4, 6'd5, 32'hffff_ffff);
    push_sample(5'd4, 6'd5, 32'hffff_ffff);

    // random part: a few busy channels with mostly steady small widths
    for (int c = 0; c < mmm_pkg::DEF_CHANNELS; c++) begin
      chan_width[c] = mmm_pkg::WIDTH_W'($urandom_range(1, 8));
    end
    for (int h = 0; h < 4; h++) begin
      hot_chan[h] = mmm_pkg::CHAN_W'($urandom_range(0, mmm_pkg::DEF_CHANNELS - 1));
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      chan = (r < 70) ? hot_chan[$urandom_range(0, 3)]
                      : mmm_pkg::CHAN_W'($urandom_range(0, mmm_pkg::DEF_CHANNELS - 1));
      if ($urandom_range(0, 15) == 0) begin
        chan_width[chan] = mmm_pkg::WIDTH_W'($urandom_range(1,
                             ($urandom_range(0, 4) == 0) ? 20 : 8));
      end
      // occasional refused beats and rare one-off wide windows
      r = $urandom_range(0, 99);
      if (r < 4) begin
        width = '0;
      end else if (r < 7) begin
        width = mmm_pkg::WIDTH_W'($urandom_range(21, 63));
      end else begin
        width = chan_width[chan];
      end
      push_sample(chan, width, pick_sample());
    end

    // drain, then watch a while for stray result beats
    s_tvalid <= 1'b0;
    wait (outstanding == 0);
    repeat (64) @(posedge clk);
    if (failures == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mmm_pkg.sv
rtl/mmm_sample_ram.sv
rtl/mmm_rank_unit.sv
rtl/multichannel_moving_median.sv
tb/mmm_median_checker.sv
tb/tb_top.sv
